// ===== design/lfu_pkg.sv =====
// ---------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU cache table
// Controller states, command/status bundles and default sizes.
// ---------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned LFU_ENTRIES     = 16;
  localparam int unsigned LFU_COUNT_WIDTH = 16;
  localparam int unsigned LFU_CAP_WIDTH   = 5;
  localparam logic [LFU_CAP_WIDTH-1:0] LFU_CAP_RESET = 5'd16;

  localparam int unsigned LFU_IN_DATA_W  = 64;  // key, value
  localparam int unsigned LFU_OUT_DATA_W = 72;  // hit, read_value, evicted, evicted_key

  localparam logic LFU_MODE_GET = 1'b0;
  localparam logic LFU_MODE_PUT = 1'b1;

  localparam logic [2:0] LFU_REG_CAPACITY = 3'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } lfu_state_t;

  typedef struct packed {
    logic load;    // latch item, restart scan
    logic scan;    // examine one entry
    logic update;  // commit table changes and result
  } lfu_cmd_t;

  typedef struct packed {
    logic scan_last;
  } lfu_status_t;

endpackage

// ===== design/lfu_ctrl.sv =====
// ---------------------------------------------------------------------------
// lfu_ctrl: sequencer for the LFU cache table
// Steps each item through load, entry scan and update; owns result valid.
// ---------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  lfu_status_t status,
  output lfu_cmd_t    cmd
);

  lfu_state_t state, state_next;
  logic       m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait for the output register to free up
        if (!m_tvalid || m_tready) begin
          cmd.update = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cmd.update)    m_tvalid_next = 1'b1;
    else if (m_tready) m_tvalid_next = 1'b0;
    else               m_tvalid_next = m_tvalid;
  end

endmodule

// ===== design/lfu_dpath.sv =====
// ---------------------------------------------------------------------------
// lfu_dpath: entry table, scan unit and result register
// One entry examined per scan cycle; ranks and counts updated per lane.
// ---------------------------------------------------------------------------
module lfu_dpath
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES     = LFU_ENTRIES,
  parameter int unsigned COUNT_WIDTH = LFU_COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lfu_cmd_t                   cmd,
  output lfu_status_t                status,
  input  logic [LFU_IN_DATA_W-1:0]   s_tdata,
  input  logic                       s_tuser,
  input  logic [LFU_CAP_WIDTH-1:0]   capacity,
  output logic [LFU_OUT_DATA_W-1:0]  m_tdata,
  output logic [$clog2(ENTRIES+1)-1:0] occupied
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned OW = $clog2(ENTRIES+1);
  localparam int unsigned CW = (OW > LFU_CAP_WIDTH) ? OW : LFU_CAP_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [ENTRIES-1:0]     entry_valid;
  logic [31:0]            entry_key   [ENTRIES];
  logic [31:0]            entry_data  [ENTRIES];
  logic [COUNT_WIDTH-1:0] use_count   [ENTRIES];
  logic [IW-1:0]          recency_rank[ENTRIES];

  // latched item
  logic        op_mode;
  logic [31:0] op_key, op_value;

  // scan state
  logic [IW-1:0]          idx;
  logic                   m_found, v_found, f_found;
  logic [IW-1:0]          m_idx, v_idx, f_idx;
  logic [31:0]            m_data, v_key;
  logic [COUNT_WIDTH-1:0] m_cnt, v_cnt;
  logic [IW-1:0]          m_rank, v_rank;

  logic                   cur_valid;
  logic [31:0]            cur_key;
  logic [COUNT_WIDTH-1:0] cur_cnt;
  logic [IW-1:0]          cur_rank;

  assign cur_valid = entry_valid[idx];
  assign cur_key   = entry_key[idx];
  assign cur_cnt   = use_count[idx];
  assign cur_rank  = recency_rank[idx];

  assign status.scan_last = (idx == IW'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_mode  <= s_tuser;
      op_key   <= s_tdata[31:0];
      op_value <= s_tdata[63:32];
      idx      <= '0;
      m_found  <= 1'b0;
      v_found  <= 1'b0;
      f_found  <= 1'b0;
    end else if (cmd.scan) begin
      idx <= idx + IW'(1);
      if (cur_valid && cur_key == op_key && !m_found) begin
        m_found <= 1'b1;
        m_idx   <= idx;
        m_data  <= entry_data[idx];
        m_cnt   <= cur_cnt;
        m_rank  <= cur_rank;
      end
      if (cur_valid && (!v_found || cur_cnt < v_cnt ||
                        (cur_cnt == v_cnt && cur_rank > v_rank))) begin
        v_found <= 1'b1;
        v_idx   <= idx;
        v_key   <= cur_key;
        v_cnt   <= cur_cnt;
        v_rank  <= cur_rank;
      end
      if (!cur_valid && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= idx;
      end
    end
  end

  // update decisions
  logic [CW-1:0] cap_ext, cap_eff;
  logic          full, evict, insert;
  logic [IW-1:0] slot;

  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0)                 cap_eff = CW'(1);
    else if (cap_ext > CW'(ENTRIES))   cap_eff = CW'(ENTRIES);
    else                               cap_eff = cap_ext;
    full   = CW'(occupied) >= cap_eff;
    evict  = (op_mode == LFU_MODE_PUT) && !m_found && full && v_found;
    insert = (op_mode == LFU_MODE_PUT) && !m_found && (evict || f_found);
    // lowest free index after the eviction
    if (evict && !(f_found && f_idx < v_idx)) slot = v_idx;
    else                                      slot = f_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupied    <= '0;
    end else if (cmd.update) begin
      // victim slot reused by the new entry stays valid
      if (evict && !(insert && slot == v_idx)) entry_valid[v_idx] <= 1'b0;
      if (insert) entry_valid[slot]  <= 1'b1;
      if (evict && !insert)      occupied <= occupied - OW'(1);
      else if (insert && !evict) occupied <= occupied + OW'(1);
    end
  end

  // per-lane table writes
  for (genvar i = 0; i < ENTRIES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (cmd.update) begin
        if (m_found) begin
          if (IW'(i) == m_idx) begin
            recency_rank[i] <= '0;
            use_count[i]    <= (m_cnt == COUNT_MAX) ? m_cnt : m_cnt + COUNT_WIDTH'(1);
            if (op_mode == LFU_MODE_PUT) entry_data[i] <= op_value;
          end else if (entry_valid[i] && recency_rank[i] < m_rank) begin
            recency_rank[i] <= recency_rank[i] + IW'(1);
          end
        end else if (insert) begin
          if (IW'(i) == slot) begin
            recency_rank[i] <= '0;
            use_count[i]    <= COUNT_WIDTH'(1);
            entry_key[i]    <= op_key;
            entry_data[i]   <= op_value;
          end else if (entry_valid[i] && !(evict && IW'(i) == v_idx) &&
                       !(evict && recency_rank[i] > v_rank)) begin
            // entries older than the victim close its gap and age: net no change
            recency_rank[i] <= recency_rank[i] + IW'(1);
          end
        end
      end
    end
  end

  // result register
  logic [31:0] rd;
  always_comb begin
    if (op_mode == LFU_MODE_PUT) rd = '0;
    else if (m_found)            rd = m_data;
    else                         rd = '1;
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      m_tdata <= {6'd0, (evict ? v_key : 32'd0), evict, rd, m_found};
    end
  end

endmodule

// ===== design/lfu_cache_table_core.sv =====
// ---------------------------------------------------------------------------
// lfu_cache_table_core: LFU key-value cache with LRU tie break
// Top level: stream ports, APB capacity register, controller and datapath.
// ---------------------------------------------------------------------------
// Each item is accepted, then a sequential scan that examines one entry at
// a time finds the key match, the victim and the first free slot, and an
// update step commits counts, ranks and the result once the output register
// is free. The next item is taken while a result still waits on the output.
module lfu_cache_table_core
  import lfu_pkg::*;
#(
  parameter int unsigned ENTRIES     = LFU_ENTRIES,
  parameter int unsigned COUNT_WIDTH = LFU_COUNT_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [LFU_IN_DATA_W-1:0]  s_tdata,   // key[31:0], value[63:32]
  input  logic                      s_tuser,   // mode
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [LFU_OUT_DATA_W-1:0] m_tdata,   // hit, read_value, evicted, evicted_key, pad
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  lfu_cmd_t    cmd;
  lfu_status_t status;
  logic [LFU_CAP_WIDTH-1:0]   capacity;
  logic [$clog2(ENTRIES+1)-1:0] occupied;

  assign pready = 1'b1;
  assign prdata = (paddr == LFU_REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= LFU_CAP_RESET;
    end else if (psel && penable && pwrite && paddr == LFU_REG_CAPACITY) begin
      capacity <= pwdata[LFU_CAP_WIDTH-1:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .status  (status),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .capacity(capacity),
    .m_tdata (m_tdata),
    .occupied(occupied)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= ($clog2(ENTRIES+1))'(ENTRIES))
    else $error("occupancy above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while scan in progress");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.update}))
    else $error("overlapping datapath commands");

endmodule

// ===== tb/lfu_cache_table_core_test.sv =====
// ---------------------------------------------------------------------------
// lfu_cache_table_core_test: self-checking bench for the LFU cache table
// Drives get/put items on the input stream, predicts hit, read value and
// victim in a local table model, and checks every output item in order.
// ---------------------------------------------------------------------------
module lfu_cache_table_core_test;
  import lfu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        evicted;
    logic [31:0] evicted_key;
    logic        hit;
    logic [31:0] read_value;
  } lookup_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [LFU_IN_DATA_W-1:0]  s_tdata = '0;   // key[31:0], value[63:32]
  logic                      s_tuser = 1'b0; // mode
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [LFU_OUT_DATA_W-1:0] m_tdata;        // hit, read_value, evicted, evicted_key, pad
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [2:0]                paddr = '0;
  logic [31:0]               pwdata = '0;
  logic [31:0]               prdata;
  logic                      pready;

  lfu_cache_table_core i_dut (.*);

  always #2 clk = ~clk;

  // local copy of the table
  logic        tbl_valid [LFU_ENTRIES] = '{default: 1'b0};
  logic [31:0] tbl_key   [LFU_ENTRIES];
  logic [31:0] tbl_data  [LFU_ENTRIES];
  logic [15:0] tbl_count [LFU_ENTRIES];
  int unsigned tbl_rank  [LFU_ENTRIES];
  int unsigned occupancy = 0;
  int unsigned capacity_reg = LFU_CAP_RESET;

  lookup_result_t pending_results[$];
  bit failed = 0;
  bit idle_en = 1;
  int unsigned hold_off = 0;
  int unsigned ready_stall = 0;
  int unsigned key_pool[24];

  task automatic make_recent(input int s);
    for (int i = 0; i < LFU_ENTRIES; i++)
      if (tbl_valid[i] && i != s && tbl_rank[i] < tbl_rank[s]) tbl_rank[i]++;
    tbl_rank[s] = 0;
  endtask

  task automatic lookup_predict(input logic mode, input logic [31:0] key,
                                input logic [31:0] val, output lookup_result_t r);
    int found;
    int victim;
    int free_slot;
    int unsigned cap;
    found = -1;
    victim = -1;
    free_slot = -1;
    r = '0;
    cap = (capacity_reg == 0) ? 1 : (capacity_reg > LFU_ENTRIES ? LFU_ENTRIES : capacity_reg);
    for (int i = LFU_ENTRIES - 1; i >= 0; i--)
      if (tbl_valid[i] && tbl_key[i] == key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (mode == LFU_MODE_PUT) tbl_data[found] = val;
      else r.read_value = tbl_data[found];
      if (tbl_count[found] != 16'hFFFF) tbl_count[found]++;
      make_recent(found);
    end else if (mode == LFU_MODE_GET) begin
      r.read_value = 32'hFFFF_FFFF;
    end else begin
      if (occupancy >= cap) begin
        for (int i = 0; i < LFU_ENTRIES; i++) begin
          if (!tbl_valid[i]) continue;
          if (victim < 0 || tbl_count[i] < tbl_count[victim] ||
              (tbl_count[i] == tbl_count[victim] && tbl_rank[i] > tbl_rank[victim]))
            victim = i;
        end
        if (victim >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = tbl_key[victim];
          tbl_valid[victim] = 1'b0;
          for (int i = 0; i < LFU_ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] > tbl_rank[victim]) tbl_rank[i]--;
          if (occupancy > 0) occupancy--;
        end
      end
      for (int i = LFU_ENTRIES - 1; i >= 0; i--)
        if (!tbl_valid[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < LFU_ENTRIES; i++)
          if (tbl_valid[i]) tbl_rank[i]++;
        tbl_valid[free_slot] = 1'b1;
        tbl_key[free_slot] = key;
        tbl_data[free_slot] = val;
        tbl_count[free_slot] = 16'd1;
        tbl_rank[free_slot] = 0;
        occupancy++;
      end
    end
  endtask

  // valid stays high between back-to-back items unless a random idle gap is inserted; caller drops it at the end
  task automatic send_item(input logic mode, input logic [31:0] key, input logic [31:0] val);
    lookup_result_t r;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {val, key};
    do @(posedge clk); while (!s_tready);
    lookup_predict(mode, key, val, r);
    pending_results.push_back(r);
  endtask

  task automatic drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_capacity(input int unsigned cap);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(LFU_REG_CAPACITY * 4);
    pwdata <= cap;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    capacity_reg = cap & 32'h1F;
  endtask

  // output side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready <= 1'b0;
        hold_off--;
      end else if (ready_stall > 0) begin
        m_tready <= 1'b0;
        ready_stall--;
      end else begin
        m_tready <= 1'b1;
        if (idle_en && $urandom_range(0, 5) == 0) ready_stall = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        failed = 1;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_tdata[0] !== exp_r.hit) begin
          $display("%0t: hit exp %b got %b", $time, exp_r.hit, m_tdata[0]);
          failed = 1;
        end
        if (m_tdata[32:1] !== exp_r.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, exp_r.read_value, m_tdata[32:1]);
          failed = 1;
        end
        if (m_tdata[33] !== exp_r.evicted) begin
          $display("%0t: evicted exp %b got %b", $time, exp_r.evicted, m_tdata[33]);
          failed = 1;
        end
        if (m_tdata[65:34] !== exp_r.evicted_key) begin
          $display("%0t: evicted_key exp %h got %h", $time, exp_r.evicted_key,
                   m_tdata[65:34]);
          failed = 1;
        end
      end
    end
  end

  task automatic test_directed;
    send_item(LFU_MODE_GET, 32'h0000_0000, 32'hFFFF_FFFF);  // miss on empty table
    send_item(LFU_MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(LFU_MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(LFU_MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(LFU_MODE_PUT, 32'h0000_0000, 32'h0000_0000);
    send_item(LFU_MODE_GET, 32'h7FFF_FFFF, 32'h0);
    send_item(LFU_MODE_GET, 32'h8000_0000, 32'h0);
    send_item(LFU_MODE_GET, 32'hFFFF_FFFF, 32'h0);
    send_item(LFU_MODE_PUT, 32'h0000_0000, 32'h1234_5678);  // overwrite
    send_item(LFU_MODE_GET, 32'h0000_0000, 32'h0);
    send_item(LFU_MODE_GET, 32'h0000_0001, 32'h0);
    drain();
  endtask

  task automatic test_eviction;
    write_capacity(2);
    // table holds two entries: once full, each new put evicts; equal counts fall to recency
    send_item(LFU_MODE_PUT, 32'd100, 32'd1);
    send_item(LFU_MODE_PUT, 32'd101, 32'd2);
    send_item(LFU_MODE_PUT, 32'd102, 32'd3);
    send_item(LFU_MODE_PUT, 32'd103, 32'd4);
    send_item(LFU_MODE_GET, 32'd102, 32'd0);
    send_item(LFU_MODE_PUT, 32'd104, 32'd5);
    send_item(LFU_MODE_PUT, 32'd105, 32'd6);
    send_item(LFU_MODE_GET, 32'd102, 32'd0);
    drain();
    write_capacity(1);
    send_item(LFU_MODE_PUT, 32'd200, 32'd7);
    send_item(LFU_MODE_PUT, 32'd201, 32'd8);
    send_item(LFU_MODE_GET, 32'd201, 32'd0);
    drain();
  endtask

  task automatic test_random(input int unsigned cap, input int n, input bit idle);
    int unsigned k;
    idle_en = idle;
    write_capacity(cap);
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
      send_item(logic'($urandom_range(0, 1)), k, $urandom());
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_off = 300;
    for (int i = 0; i < 30; i++)
      send_item(logic'($urandom_range(0, 1)), key_pool[$urandom_range(0, 23)], $urandom());
    drain();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_eviction();
    test_random(16, 120, 1);
    test_random(3, 90, 1);
    test_random(15, 100, 1);
    test_backpressure();
    test_random(8, 100, 1);
    test_random(16, 120, 0);
    if (!failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
